[hw/rtl/mdfm_pkg.sv]
// Shared types and constants for the motor drive fault monitor.
package mdfm_pkg;

    localparam int NDET       = 11;
    localparam int CNT_W      = 6;
    localparam int DET_W      = 4;
    localparam int RISK_SLOTS = 16;

    // Detector slots in the counter file
    localparam logic [DET_W-1:0] DET_CURR_LOW  = 4'd0;
    localparam logic [DET_W-1:0] DET_CURR_AVG  = 4'd1;
    localparam logic [DET_W-1:0] DET_CURR_PEAK = 4'd2;
    localparam logic [DET_W-1:0] DET_STAT_LOW  = 4'd3;
    localparam logic [DET_W-1:0] DET_STAT_HIGH = 4'd4;
    localparam logic [DET_W-1:0] DET_ERR       = 4'd5;
    localparam logic [DET_W-1:0] DET_BRD_LOW   = 4'd6;
    localparam logic [DET_W-1:0] DET_BRD_HIGH  = 4'd7;
    localparam logic [DET_W-1:0] DET_PH_U      = 4'd8;
    localparam logic [DET_W-1:0] DET_PH_V      = 4'd9;
    localparam logic [DET_W-1:0] DET_PH_W      = 4'd10;

    // Register indexes
    localparam logic [1:0] REG_CLASS   = 2'd0;
    localparam logic [1:0] REG_PHASE   = 2'd1;
    localparam logic [1:0] REG_TSENSOR = 2'd2;

    localparam logic [15:0] STAT_LOW_LIM  = 16'd1280;
    localparam logic [15:0] STAT_HIGH_LIM = 16'd1600;
    localparam logic [15:0] BRD_LOW_LIM   = 16'd1440;
    localparam logic [15:0] BRD_HIGH_LIM  = 16'd1600;
    localparam logic [15:0] ERR_LIM       = 16'd357;
    localparam logic [15:0] TASK_LIM      = 16'd800;

    // One debounce request to the shared step unit
    typedef struct packed {
        logic             en;
        logic [DET_W-1:0] det;
        logic             hit;
        logic [CNT_W-1:0] trip_n;
        logic [CNT_W-1:0] clear_n;
        logic [3:0]       bit_idx;
    } deb_req_t;

    // class group: 0 abductor, 1 rotator, 2 flexion, 3 ankle
    function automatic logic [2:0] group_of(input logic [3:0] c);
        logic [2:0] g;
        g = 3'b100;
        if (c == 4'd2 || c == 4'd3) g = 3'd0;
        else if (c == 4'd4 || c == 4'd5) g = 3'd1;
        else if (c >= 4'd6 && c <= 4'd9) g = 3'd2;
        else if (c >= 4'd10 && c <= 4'd13) g = 3'd3;
        return g;
    endfunction

    function automatic logic [15:0] cont_q88(input logic [1:0] g);
        logic [15:0] v;
        case (g)
            2'd0: v = 16'd1792;
            2'd1: v = 16'd1536;
            2'd2: v = 16'd12800;
            default: v = 16'd2048;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] peak_q88(input logic [1:0] g);
        logic [15:0] v;
        case (g)
            2'd0: v = 16'd2688;
            2'd1: v = 16'd2304;
            2'd2: v = 16'd19200;
            default: v = 16'd3072;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] cont_sq(input logic [1:0] g);
        logic [11:0] v;
        case (g)
            2'd0: v = 12'd49;
            2'd1: v = 12'd36;
            2'd2: v = 12'd2500;
            default: v = 12'd64;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] x);
        return x[15] ? 16'(-x) : 16'(x);
    endfunction

endpackage

[hw/rtl/mdfm_avg.sv]
// Iterative unit for the squared-current and limit moving averages.
module mdfm_avg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] amc,
    input  logic        lim_en,
    input  logic [11:0] lim_sq,
    output logic        done,
    output logic [15:0] avg_cur,
    output logic [15:0] avg_lim
);
    import mdfm_pkg::*;

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_SQ   = 3'd1;
    localparam logic [2:0] A_M99  = 3'd2;
    localparam logic [2:0] A_RCP  = 3'd3;
    localparam logic [2:0] A_LSQ  = 3'd4;
    localparam logic [2:0] A_LRCP = 3'd5;

    // floor(n / 100) = (n * RECIP_100) >> 28, exact for n below 2^21
    localparam logic [21:0] RECIP_100 = 22'd2684355;
    localparam logic [21:0] K99       = 22'd99;

    logic [2:0]  st_reg, st_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] lim_reg, lim_next;
    logic [15:0] amc_reg, amc_next;
    logic [31:0] sq_reg, sq_next;
    logic [20:0] acc_reg, acc_next;
    logic        len_reg, len_next;
    logic [11:0] lsq_reg, lsq_next;
    logic [31:0] mul_a;
    logic [21:0] mul_b;
    logic [53:0] prod;
    logic        fin;

    // the one multiplier, shared by every step
    assign prod = 54'(mul_a) * 54'(mul_b);

    always_comb
    begin
        st_next  = st_reg;
        cur_next = cur_reg;
        lim_next = lim_reg;
        amc_next = amc_reg;
        sq_next  = sq_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        lsq_next = lsq_reg;
        mul_a    = '0;
        mul_b    = '0;
        fin      = 1'b0;
        unique case (st_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    amc_next = amc;
                    len_next = lim_en;
                    lsq_next = lim_sq;
                    st_next  = A_SQ;
                end
            end
            A_SQ:
            begin
                mul_a   = 32'(amc_reg);
                mul_b   = 22'(amc_reg);
                sq_next = prod[31:0];
                st_next = A_M99;
            end
            A_M99:
            begin
                // avg*65536 has zero low bits, so dividing by 65536 first is exact
                mul_a    = sq_reg;
                mul_b    = K99;
                acc_next = 21'(cur_reg) + prod[36:16];
                st_next  = A_RCP;
            end
            A_RCP:
            begin
                mul_a    = 32'(acc_reg);
                mul_b    = RECIP_100;
                cur_next = prod[43:28];
                st_next  = A_LSQ;
            end
            A_LSQ:
            begin
                if (len_reg)
                begin
                    mul_a    = 32'(lsq_reg);
                    mul_b    = K99;
                    acc_next = 21'(lim_reg) + prod[20:0];
                    st_next  = A_LRCP;
                end
                else
                begin
                    st_next = A_IDLE;
                    fin     = 1'b1;
                end
            end
            A_LRCP:
            begin
                mul_a    = 32'(acc_reg);
                mul_b    = RECIP_100;
                lim_next = prod[43:28];
                st_next  = A_IDLE;
                fin      = 1'b1;
            end
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= A_IDLE;
            cur_reg <= '0;
            lim_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cur_reg <= cur_next;
            lim_reg <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amc_reg <= amc_next;
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        len_reg <= len_next;
        lsq_reg <= lsq_next;
    end

    assign done    = fin;
    assign avg_cur = cur_next;
    assign avg_lim = lim_next;
endmodule

[hw/rtl/mdfm_deb.sv]
// Shared debounce step over the trip/clear counter file and the risk flags.
module mdfm_deb
(
    input  logic              clk,
    input  logic              rst_n,
    input  mdfm_pkg::deb_req_t req,
    input  logic              direct_en,
    input  logic [15:0]       direct_mask,
    input  logic [15:0]       direct_val,
    output logic [15:0]       flags
);
    import mdfm_pkg::*;

    logic [CNT_W-1:0] trip_reg [NDET];
    logic [CNT_W-1:0] clr_reg [NDET];
    logic [15:0]      flags_reg;
    logic [CNT_W-1:0] t_new, c_new;
    logic [3:0]       d;

    assign d = req.det;

    always_comb
    begin
        if (req.hit)
        begin
            t_new = trip_reg[d] + 1'b1;
            c_new = '0;
        end
        else
        begin
            t_new = '0;
            c_new = clr_reg[d] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            for (int i = 0; i < NDET; i++)
            begin
                trip_reg[i] <= '0;
                clr_reg[i]  <= '0;
            end
        end
        else if (req.en)
        begin
            trip_reg[d] <= (t_new > req.trip_n) ? '0 : t_new;
            clr_reg[d]  <= (c_new > req.clear_n) ? '0 : c_new;
            if (t_new > req.trip_n)
                flags_reg[req.bit_idx] <= 1'b1;
            if (c_new > req.clear_n)
                flags_reg[req.bit_idx] <= 1'b0;
        end
        else if (direct_en)
            flags_reg <= (flags_reg & ~direct_mask) | (direct_val & direct_mask);
    end

    assign flags = flags_reg;

    a_one_fire: assert property (@(posedge clk) disable iff (!rst_n)
        req.en |-> !(t_new > req.trip_n && c_new > req.clear_n))
        else $error("trip and clear fired together");
    a_det_range: assert property (@(posedge clk) disable iff (!rst_n)
        req.en |-> req.det < 4'(NDET))
        else $error("detector slot out of range");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.en && direct_en))
        else $error("counter step and direct write together");
endmodule

[hw/rtl/motor_drive_fault_monitor.sv]
// Top level of the motor drive fault monitor: sequencer, registers, handshakes.
// One tick of drive measurements goes in per transfer and one risk word comes out.
// A tick passes through these steps from its transfer to the next possible one: the
// moving-average unit runs the square, the 0.99 weighting and both divisions by 100
// through one shared multiplier (the limit average is skipped for an unlisted class);
// a sequencer then walks the eleven debounce detectors and the two direct bits through
// one shared counter step, one step per detector and one for the direct bits; the
// output register is loaded; and the block returns to idle. in_ready is low while a
// tick is at work; the result waits in the output register so the next tick can be
// accepted before it is taken, and a new result is held back until it is.
module motor_drive_fault_monitor
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              motor_current,
    input  logic signed [11:0]              stator_temp,
    input  logic signed [11:0]              board_temp,
    input  logic signed [15:0]              phase_u_current,
    input  logic signed [15:0]              phase_v_current,
    input  logic signed [15:0]              phase_w_current,
    input  logic signed [15:0]              position_error,
    input  logic [15:0]                     low_task_time,
    input  logic [15:0]                     mid_task_time,
    input  logic                            hall_fault,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mdfm_pkg::RISK_SLOTS-1:0] risk_word,
    output logic                            shutdown_request,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mdfm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_AVG  = 2'd1;
    localparam logic [1:0] S_DEB  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  st_reg;
    logic [3:0]  step_reg;
    logic [3:0]  cls_reg;
    logic [14:0] ptl_reg;
    logic        tsp_reg;

    logic [15:0] amc_reg, st_reg_v, bt_reg, pu_reg, pv_reg, pw_reg, pe_reg;
    logic        ovr_reg, hall_reg;
    logic        ov_reg;
    logic [RISK_SLOTS-1:0] rw_reg;

    logic [2:0]  grp;
    logic        gval;
    logic        avg_done;
    logic [15:0] avg_cur, avg_lim;
    logic [15:0] cur_q, lim_q;
    deb_req_t    req;
    logic        dir_en;
    logic [15:0] dir_mask, dir_val, flags;
    logic [1:0]  cfg_idx;

    assign grp  = group_of(cls_reg);
    assign gval = !grp[2];
    assign in_ready = (st_reg == S_IDLE);
    assign pready = 1'b1;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_CLASS:   prdata = {28'h0, cls_reg};
            REG_PHASE:   prdata = {17'h0, ptl_reg};
            REG_TSENSOR: prdata = {31'h0, tsp_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg <= '0;
            ptl_reg <= 15'h7fff;
            tsp_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_CLASS:   cls_reg <= pwdata[3:0];
                REG_PHASE:   ptl_reg <= pwdata[14:0];
                REG_TSENSOR: tsp_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    mdfm_avg u_avg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_valid && in_ready),
        .amc     (mag16(motor_current)),
        .lim_en  (gval),
        .lim_sq  (cont_sq(grp[1:0])),
        .done    (avg_done),
        .avg_cur (avg_cur),
        .avg_lim (avg_lim)
    );

    always_ff @(posedge clk)
    begin
        if (avg_done)
        begin
            cur_q <= avg_cur;
            lim_q <= avg_lim;
        end
        if (in_valid && in_ready)
        begin
            amc_reg  <= mag16(motor_current);
            st_reg_v <= {{4{stator_temp[11]}}, stator_temp};
            bt_reg   <= {{4{board_temp[11]}}, board_temp};
            pu_reg   <= mag16(phase_u_current);
            pv_reg   <= mag16(phase_v_current);
            pw_reg   <= mag16(phase_w_current);
            pe_reg   <= mag16(position_error);
            ovr_reg  <= (low_task_time > TASK_LIM) || (mid_task_time > TASK_LIM);
            hall_reg <= hall_fault;
        end
    end

    // Debounce schedule, one detector per step (step 5 writes the two direct bits), in the order of the risk list
    always_comb
    begin
        req = '0;
        dir_en = 1'b0;
        dir_mask = '0;
        dir_val = '0;
        if (st_reg == S_DEB)
        begin
            case (step_reg)
                4'd0:
                begin
                    req = '{gval, DET_CURR_LOW, amc_reg > cont_q88(grp[1:0]),
                            6'd30, 6'd30, 4'd0};
                end
                4'd1: req = '{1'b1, DET_CURR_AVG, cur_q > lim_q, 6'd30, 6'd30, 4'd1};
                4'd2:
                begin
                    req = '{gval, DET_CURR_PEAK, amc_reg > peak_q88(grp[1:0]),
                            6'd3, 6'd30, 4'd2};
                end
                4'd3:
                begin
                    req = '{tsp_reg, DET_STAT_LOW, $signed(st_reg_v) > $signed(STAT_LOW_LIM),
                            6'd10, 6'd30, 4'd4};
                end
                4'd4:
                begin
                    req = '{tsp_reg, DET_STAT_HIGH,
                            $signed(st_reg_v) > $signed(STAT_HIGH_LIM), 6'd10, 6'd50, 4'd5};
                end
                4'd5:
                begin
                    dir_en = 1'b1;
                    dir_mask = 16'h1040;
                    dir_val = {3'b0, hall_reg, 5'b0, ovr_reg, 6'b0};
                end
                4'd6:
                begin
                    req = '{grp == 3'd2, DET_ERR, pe_reg > ERR_LIM, 6'd30, 6'd30, 4'd7};
                end
                4'd7:
                begin
                    req = '{1'b1, DET_BRD_LOW, $signed(bt_reg) > $signed(BRD_LOW_LIM),
                            6'd10, 6'd30, 4'd13};
                end
                4'd8:
                begin
                    req = '{1'b1, DET_BRD_HIGH, $signed(bt_reg) > $signed(BRD_HIGH_LIM),
                            6'd10, 6'd30, 4'd14};
                end
                4'd9:  req = '{1'b1, DET_PH_U, pu_reg > {1'b0, ptl_reg}, 6'd3, 6'd3, 4'd15};
                4'd10: req = '{1'b1, DET_PH_V, pv_reg > {1'b0, ptl_reg}, 6'd3, 6'd3, 4'd15};
                4'd11: req = '{1'b1, DET_PH_W, pw_reg > {1'b0, ptl_reg}, 6'd3, 6'd3, 4'd15};
                default: ;
            endcase
        end
    end

    mdfm_deb u_deb
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .direct_en   (dir_en),
        .direct_mask (dir_mask),
        .direct_val  (dir_val),
        .flags       (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (st_reg == S_OUT && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_valid && out_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (in_valid) st_reg <= S_AVG;
                S_AVG:
                begin
                    step_reg <= '0;
                    if (avg_done) st_reg <= S_DEB;
                end
                S_DEB:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11) st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && (!ov_reg || out_ready))
            rw_reg <= flags;
    end

    assign out_valid        = ov_reg;
    assign risk_word        = rw_reg;
    assign shutdown_request = rw_reg[15];

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> st_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(risk_word))
        else $error("result lost while stalled");
    a_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> shutdown_request == risk_word[15])
        else $error("shutdown bit mismatch");
endmodule

[dv/motor_drive_fault_monitor_test.sv]
// Self-checking testbench for the motor drive fault monitor.
module motor_drive_fault_monitor_test;
    import mdfm_pkg::*;

    typedef struct {
        logic signed [15:0] mc;
        logic signed [11:0] st;
        logic signed [11:0] bt;
        logic signed [15:0] pu;
        logic signed [15:0] pv;
        logic signed [15:0] pw;
        logic signed [15:0] perr;
        logic [15:0]        lt;
        logic [15:0]        mt;
        logic               hall;
    } tick_t;

    typedef struct {
        tick_t       t;
        bit          chk;
        logic [15:0] risk;
    } tick_row_t;

    localparam int CONT_Q88 [4] = '{1792, 1536, 12800, 2048};
    localparam int PEAK_Q88 [4] = '{2688, 2304, 19200, 3072};
    localparam int CONT_SQ  [4] = '{49, 36, 2500, 64};
    localparam int CUR_LVLS [9] = '{1792, 1536, 12800, 2048, 2688, 2304, 19200, 3072, 0};

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] motor_current, phase_u_current, phase_v_current, phase_w_current;
    logic signed [15:0] position_error;
    logic signed [11:0] stator_temp, board_temp;
    logic [15:0] low_task_time, mid_task_time;
    logic hall_fault;
    logic [15:0] risk_word;
    logic shutdown_request;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;

    // predictor copy of configuration and state
    int unsigned cfg_class, cfg_level, cfg_sensor;
    logic [15:0] flags;
    int unsigned trip_cnt [NDET];
    int unsigned clr_cnt [NDET];
    longint unsigned avg_cur_pwr, avg_lim_pwr;

    logic [15:0] risk_q[$];
    int errors, sent, snd_idle, rcv_idle;
    tick_row_t dir_tab[$];

    motor_drive_fault_monitor dut (.*);

    always #5 clk = ~clk;

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int class_group(int unsigned c);
        if (c == 2 || c == 3) return 0;
        if (c == 4 || c == 5) return 1;
        if (c >= 6 && c <= 9) return 2;
        if (c >= 10 && c <= 13) return 3;
        return -1;
    endfunction

    function automatic void persist(int d, bit hit, int unsigned trip_n, int unsigned clr_n,
                                    int b);
        if (hit) begin
            trip_cnt[d] = (trip_cnt[d] + 1) & 63;
            clr_cnt[d] = 0;
        end
        else begin
            clr_cnt[d] = (clr_cnt[d] + 1) & 63;
            trip_cnt[d] = 0;
        end
        if (trip_cnt[d] > trip_n) begin
            trip_cnt[d] = 0;
            flags[b] = 1'b1;
        end
        if (clr_cnt[d] > clr_n) begin
            clr_cnt[d] = 0;
            flags[b] = 1'b0;
        end
    endfunction

    function automatic logic [15:0] predict_risk(tick_t t);
        int g;
        int amc;
        int st;
        int bt;
        int ph [3];
        longint unsigned sq;
        g = class_group(cfg_class);
        amc = (t.mc < 0) ? -int'(t.mc) : int'(t.mc);
        st = t.st;
        bt = t.bt;
        ph[0] = t.pu;
        ph[1] = t.pv;
        ph[2] = t.pw;
        if (g >= 0)
            persist(DET_CURR_LOW, amc > CONT_Q88[g], 30, 30, 0);
        sq = longint'(amc) * longint'(amc);
        avg_cur_pwr = ((avg_cur_pwr * 65536 + 99 * sq) / 6553600) & 16'hFFFF;
        if (g >= 0)
            avg_lim_pwr = ((avg_lim_pwr + 99 * CONT_SQ[g]) / 100) & 16'hFFFF;
        persist(DET_CURR_AVG, avg_cur_pwr > avg_lim_pwr, 30, 30, 1);
        if (g >= 0)
            persist(DET_CURR_PEAK, amc > PEAK_Q88[g], 3, 30, 2);
        if (cfg_sensor != 0) begin
            persist(DET_STAT_LOW, st > 1280, 10, 30, 4);
            persist(DET_STAT_HIGH, st > 1600, 10, 50, 5);
        end
        flags[6] = (t.lt > 800) || (t.mt > 800);
        if (g == 2)
            persist(DET_ERR, (t.perr < 0 ? -int'(t.perr) : int'(t.perr)) > 357, 30, 30, 7);
        flags[12] = t.hall;
        persist(DET_BRD_LOW, bt > 1440, 10, 30, 13);
        persist(DET_BRD_HIGH, bt > 1600, 10, 30, 14);
        for (int p = 0; p < 3; p++)
            persist(DET_PH_U + p, (ph[p] < 0 ? -ph[p] : ph[p]) > int'(cfg_level), 3, 3, 15);
        return flags;
    endfunction

    function automatic void add_row(int mc, int st, int bt, int pu, int pv, int pw, int pe,
                                    int lt, int mt, bit hall, bit chk, logic [15:0] risk);
        tick_row_t r;
        r.t = '{16'(mc), 12'(st), 12'(bt), 16'(pu), 16'(pv), 16'(pw), 16'(pe), 16'(lt),
                16'(mt), hall};
        r.chk = chk;
        r.risk = risk;
        dir_tab.push_back(r);
    endfunction

    function automatic int jitter(int c, int spread);
        return c + $urandom_range(2 * spread) - spread;
    endfunction

    function automatic logic [15:0] pick_s16(int lvl);
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'(($urandom_range(1) ? -1 : 1) * jitter(lvl, 3));
            2: return 16'(jitter(0, 4000));
            default: return ($urandom_range(1) ? 16'h8000 : 16'h7FFF) ^ 16'($urandom_range(1));
        endcase
    endfunction

    function automatic logic [11:0] pick_temp();
        case ($urandom_range(2))
            0: return 12'($urandom);
            1: return 12'(jitter($urandom_range(1) ? 1440 : ($urandom_range(1) ? 1280 : 1600), 3));
            default: return 12'(jitter(0, 1500));
        endcase
    endfunction

    function automatic logic [15:0] pick_task();
        return $urandom_range(1) ? 16'($urandom) : 16'(jitter(800, 2));
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.mc = pick_s16(CUR_LVLS[$urandom_range(8)]);
        t.st = pick_temp();
        t.bt = pick_temp();
        t.pu = pick_s16(cfg_level);
        t.pv = pick_s16(cfg_level);
        t.pw = pick_s16(cfg_level);
        t.perr = pick_s16(357);
        t.lt = pick_task();
        t.mt = pick_task();
        t.hall = $urandom_range(1);
        return t;
    endfunction

    task automatic send_tick(input tick_t t, input bit chk, input logic [15:0] risk);
        logic [15:0] exp_risk;
        if (sent < 620) begin
            snd_idle = 21;
            rcv_idle = 86;
        end
        else if (sent < 1240) begin
            snd_idle = 86;
            rcv_idle = 21;
        end
        else begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        motor_current <= t.mc;
        stator_temp <= t.st;
        board_temp <= t.bt;
        phase_u_current <= t.pu;
        phase_v_current <= t.pv;
        phase_w_current <= t.pw;
        position_error <= t.perr;
        low_task_time <= t.lt;
        mid_task_time <= t.mt;
        hall_fault <= t.hall;
        do @(posedge clk); while (!in_ready);
        exp_risk = predict_risk(t);
        risk_q.push_back(chk ? risk : exp_risk);
        sent++;
    endtask

    // block is idle here: in_valid low and every result drained
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CLASS:   cfg_class = val & 15;
            REG_PHASE:   cfg_level = val & 32767;
            REG_TSENSOR: cfg_sensor = val & 1;
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (risk_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // result checker
    initial begin
        logic [15:0] want;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (risk_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: risk_word=%h", risk_word);
                end
                else begin
                    want = risk_q.pop_front();
                    if (risk_word !== want || shutdown_request !== want[15]) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: risk_word exp %h got %h, shutdown exp %b got %b",
                                     want, risk_word, want[15], shutdown_request);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial begin
        tick_t base;
        tick_t t;
        int unsigned classes [9];
        int unsigned levels [9];
        classes = '{2, 4, 6, 9, 10, 13, 15, 1, 7};
        rst_n = 1'b0;
        in_valid = 1'b0;
        {motor_current, stator_temp, board_temp, phase_u_current, phase_v_current} = '0;
        {phase_w_current, position_error, low_task_time, mid_task_time, hall_fault} = '0;
        {psel, penable, pwrite, paddr, pwdata} = '0;
        errors = 0;
        sent = 0;
        snd_idle = 21;
        rcv_idle = 86;
        cfg_class = 0;
        cfg_level = 32767;
        cfg_sensor = 1;
        flags = '0;
        foreach (trip_cnt[i]) begin
            trip_cnt[i] = 0;
            clr_cnt[i] = 0;
        end
        avg_cur_pwr = 0;
        avg_lim_pwr = 0;
        levels = '{32767, 0, 1000, 20000, 5, 32767, 300, $urandom_range(32767),
                   $urandom_range(32767)};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config (unlisted class, sensor present)
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 16'h1000);
        add_row(0, 0, 0, 0, 0, 0, 0, 801, 0, 0, 1, 16'h0040);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 801, 0, 1, 16'h0040);
        add_row(0, 0, 0, 0, 0, 0, 0, 800, 800, 0, 1, 16'h0000);
        add_row(-32768, 2047, 2047, -32768, 0, 0, -32768, 65535, 65535, 1, 1, 16'h1040);
        add_row(32767, -2048, -2048, 0, 32767, -32767, 32767, 0, 0, 0, 1, 16'h0000);
        // one phase held at full scale long enough to trip, others quiet
        repeat (5) add_row(0, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
        // board and stator just above limits held until latched
        repeat (12) add_row(0, 1601, 1601, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        foreach (dir_tab[i]) send_tick(dir_tab[i].t, dir_tab[i].chk, dir_tab[i].risk);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            write_reg(REG_CLASS, classes[ph]);
            write_reg(REG_PHASE, levels[ph]);
            write_reg(REG_TSENSOR, (ph % 3 == 2) ? 0 : 1);
            for (int n = 0; n < 203; ) begin
                // a held condition with some noise so the persistence filters latch
                base = rand_tick();
                for (int k = $urandom_range(1, 45); k > 0 && n < 203; k--, n++) begin
                    t = ($urandom_range(99) < 80) ? base : rand_tick();
                    send_tick(t, 1'b0, 16'h0000);
                end
            end
        end
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
